### sv/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned HeapBytes   = 1024;
  localparam int unsigned HeaderBytes = 12;

  localparam int unsigned AddrW = $clog2(HeapBytes);   // heap offset
  localparam int unsigned SizeW = AddrW + 1;           // stored block size
  localparam int unsigned PosW  = AddrW + 2;           // walk pointer, run sum

  localparam logic [SizeW-1:0] HeapSize = SizeW'(HeapBytes);
  localparam logic [PosW-1:0]  HdrPos   = PosW'(HeaderBytes);
  localparam logic [PosW-1:0]  HeapPos  = PosW'(HeapBytes);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_NO_ROOM = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             free_f;
    logic [SizeW-1:0] size;
  } entry_t;

  typedef enum logic [1:0] {
    RD_POS = 2'd0,
    RD_P   = 2'd1,
    RD_OFF = 2'd2
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_CLEAR = 3'd1,
    WR_INVAL = 3'd2,
    WR_START = 3'd3,
    WR_NF    = 3'd4,
    WR_FREE  = 3'd5
  } wr_sel_e;

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_OK   = 2'd1,
    RES_FAIL = 2'd2,
    RES_FREE = 2'd3
  } res_sel_e;

  typedef enum logic [1:0] {
    POS_HOLD = 2'd0,
    POS_ADD_FREE = 2'd1,
    POS_ADD_USED = 2'd2
  } pos_op_e;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    rd_sel_e  rd_sel;
    wr_sel_e  wr_sel;
    res_sel_e res_sel;
    pos_op_e  pos_op;
    logic     start_set;
    logic     p_init;
    logic     p_next;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rd_valid;
    logic rd_free;
    logic size_nz;
    logic pos_ge_heap;
    logic pos_eq_start;
    logic sum_ge_need;
    logic p_in_run;
    logic p_is_start;
    logic nxt_le_p;
    logic split;
    logic nf_in_heap;
  } dp_stat_t;

endpackage

### sv/ffha_datapath.sv
// ----------------------------------------------------------------------------
// ffha_datapath
// Header store, walk pointers, run sum and result registers.
// ----------------------------------------------------------------------------
module ffha_datapath import ffha_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [AddrW-1:0]     req_size_i,
  input  logic [AddrW-1:0]     free_offset_i,
  output dp_stat_t             stat_o,
  output logic                 status_o,
  output logic [AddrW-1:0]     block_offset_o,
  output logic [AddrW-1:0]     granted_size_o
);

  entry_t mem [HeapBytes];
  entry_t rdata_q;

  logic [AddrW-1:0] clr_q, clr_d;
  logic [PosW-1:0]  pos_q, start_q, sum_q, p_q;
  logic [AddrW-1:0] req_q, off_q;
  logic             res_status_q;
  logic [AddrW-1:0] res_off_q, res_size_q;

  logic [PosW-1:0]  req_ext, size_ext, need, nxt, run_end, nf, granted, nf_size;
  logic [AddrW-1:0] rd_addr, wr_addr;
  entry_t           wr_data;
  logic             wr_en;

  assign req_ext  = PosW'(req_q);
  assign size_ext = PosW'(rdata_q.size);
  assign need     = req_ext + HdrPos;
  assign nxt      = p_q + size_ext;
  assign run_end  = start_q + sum_q;
  assign nf       = start_q + HdrPos + req_ext;
  assign nf_size  = sum_q - HdrPos - req_ext;
  assign granted  = stat_o.split ? req_ext : (sum_q - HdrPos);

  always_comb begin
    stat_o.clr_last     = (clr_q == AddrW'(HeapBytes - 1));
    stat_o.rd_valid     = rdata_q.valid;
    stat_o.rd_free      = rdata_q.free_f;
    stat_o.size_nz      = (rdata_q.size != '0);
    stat_o.pos_ge_heap  = (pos_q >= HeapPos);
    stat_o.pos_eq_start = (pos_q == start_q);
    stat_o.sum_ge_need  = (sum_q >= need);
    stat_o.p_in_run     = (p_q < run_end) && (p_q < HeapPos);
    stat_o.p_is_start   = (p_q == start_q);
    stat_o.nxt_le_p     = (nxt <= p_q);
    stat_o.split        = (sum_q >= need + HdrPos);
    stat_o.nf_in_heap   = (nf < HeapPos);
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_POS:  rd_addr = pos_q[AddrW-1:0];
      RD_P:    rd_addr = p_q[AddrW-1:0];
      default: rd_addr = off_q;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = clr_q;
    wr_data = '0;
    unique case (cmd_i.wr_sel)
      WR_CLEAR: begin
        if (clr_q == '0) wr_data = '{valid: 1'b1, free_f: 1'b1, size: HeapSize};
      end
      WR_INVAL: begin
        wr_addr = p_q[AddrW-1:0];
        wr_data = '{valid: 1'b0, free_f: rdata_q.free_f, size: rdata_q.size};
      end
      WR_START: begin
        wr_addr = start_q[AddrW-1:0];
        wr_data = '{valid: 1'b1, free_f: 1'b0, size: granted[SizeW-1:0]};
      end
      WR_NF: begin
        wr_addr = nf[AddrW-1:0];
        wr_data = '{valid: 1'b1, free_f: 1'b1, size: nf_size[SizeW-1:0]};
      end
      WR_FREE: begin
        wr_addr = off_q;
        wr_data = '{valid: 1'b1, free_f: 1'b1,
                    size: rdata_q.size + SizeW'(HeaderBytes)};
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rdata_q <= mem[rd_addr];
  end

  assign clr_d = (cmd_i.wr_sel == WR_CLEAR) ? clr_q + 1'b1 : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_size_i;
      off_q <= free_offset_i;
      pos_q <= '0;
    end else begin
      case (cmd_i.pos_op)
        POS_ADD_FREE: pos_q <= pos_q + size_ext;
        POS_ADD_USED: pos_q <= pos_q + HdrPos + size_ext;
        default:      pos_q <= pos_q;
      endcase
    end
    if (cmd_i.pos_op == POS_ADD_FREE) sum_q <= sum_q + size_ext;
    if (cmd_i.start_set) begin
      start_q <= pos_q;
      sum_q   <= '0;
    end
    if (cmd_i.p_init) p_q <= start_q;
    else if (cmd_i.p_next) p_q <= nxt;
    case (cmd_i.res_sel)
      RES_OK: begin
        res_status_q <= STATUS_DONE;
        res_off_q    <= start_q[AddrW-1:0];
        res_size_q   <= granted[AddrW-1:0];
      end
      RES_FAIL: begin
        res_status_q <= STATUS_NO_ROOM;
        res_off_q    <= '0;
        res_size_q   <= '0;
      end
      RES_FREE: begin
        res_status_q <= STATUS_DONE;
        res_off_q    <= off_q;
        res_size_q   <= '0;
      end
      default: ;
    endcase
  end

  assign status_o       = res_status_q;
  assign block_offset_o = res_off_q;
  assign granted_size_o = res_size_q;

endmodule

### sv/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for clearing, header walks, run merging and responses.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     cmd_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy,
  output logic     done_o
);

  typedef enum logic [16:0] {
    S_CLEAR = 17'h00001,
    S_IDLE  = 17'h00002,
    S_F_RD  = 17'h00004,
    S_F_EV  = 17'h00008,
    S_O_CHK = 17'h00010,
    S_O_EV  = 17'h00020,
    S_I_CHK = 17'h00040,
    S_I_EV  = 17'h00080,
    S_I_END = 17'h00100,
    S_K_CHK = 17'h00200,
    S_K_EV  = 17'h00400,
    S_K_END = 17'h00800,
    S_M_CHK = 17'h01000,
    S_M_EV  = 17'h02000,
    S_M_WS  = 17'h04000,
    S_M_WN  = 17'h08000,
    S_RESP  = 17'h10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{load: 1'b0, rd_en: 1'b0, rd_sel: RD_POS, wr_sel: WR_NONE,
                res_sel: RES_NONE, pos_op: POS_HOLD, start_set: 1'b0,
                p_init: 1'b0, p_next: 1'b0};
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.wr_sel = WR_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = (cmd_i == CMD_FREE) ? S_F_RD : S_O_CHK;
        end
      end
      S_F_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_OFF;
        state_d      = S_F_EV;
      end
      S_F_EV: begin
        if (stat_i.rd_valid && !stat_i.rd_free) cmd_o.wr_sel = WR_FREE;
        cmd_o.res_sel = RES_FREE;
        state_d       = S_RESP;
      end
      S_O_CHK: begin
        if (stat_i.pos_ge_heap) begin
          cmd_o.res_sel = RES_FAIL;
          state_d       = S_RESP;
        end else begin
          cmd_o.rd_en     = 1'b1;
          cmd_o.start_set = 1'b1;
          state_d         = S_O_EV;
        end
      end
      S_O_EV, S_I_EV: begin
        if (!stat_i.rd_valid && state_q == S_O_EV) begin
          cmd_o.res_sel = RES_FAIL;
          state_d       = S_RESP;
        end else if (stat_i.rd_valid && stat_i.rd_free && stat_i.size_nz) begin
          cmd_o.pos_op = POS_ADD_FREE;
          state_d      = S_I_CHK;
        end else begin
          state_d = S_I_END;
        end
      end
      S_I_CHK: begin
        if (stat_i.pos_ge_heap) begin
          state_d = S_I_END;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_I_EV;
        end
      end
      S_I_END: begin
        if (stat_i.sum_ge_need) begin
          cmd_o.p_init = 1'b1;
          state_d      = S_M_CHK;
        end else begin
          state_d = S_K_CHK;
        end
      end
      S_K_CHK: begin
        if (stat_i.pos_ge_heap) begin
          state_d = S_K_END;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_K_EV;
        end
      end
      S_K_EV: begin
        if (stat_i.rd_valid && !stat_i.rd_free) begin
          cmd_o.pos_op = POS_ADD_USED;
          state_d      = S_K_CHK;
        end else begin
          state_d = S_K_END;
        end
      end
      S_K_END: begin
        if (stat_i.pos_eq_start) begin
          cmd_o.res_sel = RES_FAIL;
          state_d       = S_RESP;
        end else begin
          state_d = S_O_CHK;
        end
      end
      S_M_CHK: begin
        if (stat_i.p_in_run) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_P;
          state_d      = S_M_EV;
        end else begin
          state_d = S_M_WS;
        end
      end
      S_M_EV: begin
        if (!stat_i.p_is_start) cmd_o.wr_sel = WR_INVAL;
        if (stat_i.nxt_le_p) begin
          state_d = S_M_WS;
        end else begin
          cmd_o.p_next = 1'b1;
          state_d      = S_M_CHK;
        end
      end
      S_M_WS: begin
        cmd_o.wr_sel  = WR_START;
        cmd_o.res_sel = RES_OK;
        state_d       = (stat_i.split && stat_i.nf_in_heap) ? S_M_WN : S_RESP;
      end
      S_M_WN: begin
        cmd_o.wr_sel = WR_NF;
        state_d      = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for two cycles");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");

  a_clear_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (busy && !done_o))
    else $error("idle or strobe during clearing pass");

  a_merge_after_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_M_WS) |=> (state_q == S_M_WN || state_q == S_RESP))
    else $error("grant write not followed by split write or response");

endmodule

### sv/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator whose block headers live in a 1024-entry header store.
// ----------------------------------------------------------------------------
//
// Channel   | Handshake              | Signals
// ----------+------------------------+-------------------------------------------
// command   | start && !busy         | cmd_i, req_size_i, free_offset_i
// response  | done_o (one cycle)     | status_o, block_offset_o, granted_size_o
//
// Sequence: a free reads the header at free_offset_i, marks it free if it is
// a valid used block and raises the strobe; the next command is taken once
// busy falls. An allocation walks the headers one at a time through the
// store's single registered read port, summing each run of free blocks, then
// merges the headers of the chosen run, writes the granted header and any split
// remainder, and raises the strobe; the total scales with the number of blocks.
// Reset: after rst_ni rises a clearing pass writes all 1024 header entries,
// one per cycle; busy stays high throughout the pass.
// Stalls: the receiver cannot stall; done_o is high for one cycle only per response.
//
module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             cmd_i,
  input  logic [AddrW-1:0] req_size_i,
  input  logic [AddrW-1:0] free_offset_i,
  output logic             done_o,
  output logic             status_o,
  output logic [AddrW-1:0] block_offset_o,
  output logic [AddrW-1:0] granted_size_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequence the walk, merge and header updates.
  ffha_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // Hold the header store, pointers and the response registers.
  ffha_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .req_size_i     (req_size_i),
    .free_offset_i  (free_offset_i),
    .stat_o         (dp_stat),
    .status_o       (status_o),
    .block_offset_o (block_offset_o),
    .granted_size_o (granted_size_o)
  );

endmodule
